>>> rtl/dsu_pkg.sv
// Shared types and constants for the disjoint-set union engine.
`timescale 1ns / 1ps

package dsu_pkg;

  localparam int NODE_W   = 10;
  localparam int SIZE_W   = 11;
  localparam int NODE_CNT = 1 << NODE_W;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 16;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FA_RD,
    ST_FA_CHK,
    ST_CA_RD,
    ST_CA_CHK,
    ST_FB_RD,
    ST_FB_CHK,
    ST_CB_RD,
    ST_CB_CHK,
    ST_SZ_B,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_A,
    CUR_B,
    CUR_PAR
  } cur_sel_e;

  typedef struct packed {
    logic     clr_step;
    logic     load_req;
    cur_sel_e cur_sel;
    logic     root_we_a;
    logic     root_we_b;
    logic     par_rd;
    logic     par_wr;
    logic     root_sel_b;
    logic     sz_rd_a;
    logic     sz_rd_b;
    logic     link;
    logic     res_null;
    logic     res_same;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic par_is_root;
    logic cur_is_ra;
    logic cur_is_rb;
    logic roots_eq;
    logic req_oob;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/dsu_ctrl.sv
// Sequencer for the clearing pass, the two root walks, compression and linking.
`timescale 1ns / 1ps

module dsu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  dsu_pkg::sts_t sts_i,
  output dsu_pkg::cmd_t cmd_o
);

  dsu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsu_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.cur_sel = dsu_pkg::CUR_HOLD;
    req_ready_o = 1'b0;
    case (state_q)
      dsu_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = dsu_pkg::ST_IDLE;
        end
      end
      dsu_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.req_oob) begin
            cmd_o.res_null = 1'b1;
            state_d = dsu_pkg::ST_DONE;
          end else begin
            state_d = dsu_pkg::ST_FA_RD;
          end
        end
      end
      dsu_pkg::ST_FA_RD: begin
        cmd_o.par_rd = 1'b1;
        state_d = dsu_pkg::ST_FA_CHK;
      end
      dsu_pkg::ST_FA_CHK: begin
        if (sts_i.par_is_root) begin
          cmd_o.root_we_a = 1'b1;
          cmd_o.cur_sel   = dsu_pkg::CUR_A;
          state_d = dsu_pkg::ST_CA_RD;
        end else begin
          cmd_o.cur_sel = dsu_pkg::CUR_PAR;
          state_d = dsu_pkg::ST_FA_RD;
        end
      end
      dsu_pkg::ST_CA_RD: begin
        if (sts_i.cur_is_ra) begin
          cmd_o.cur_sel = dsu_pkg::CUR_B;
          state_d = dsu_pkg::ST_FB_RD;
        end else begin
          cmd_o.par_rd = 1'b1;
          state_d = dsu_pkg::ST_CA_CHK;
        end
      end
      dsu_pkg::ST_CA_CHK: begin
        // repoint this node at the root, then follow its old parent
        cmd_o.par_wr  = 1'b1;
        cmd_o.cur_sel = dsu_pkg::CUR_PAR;
        state_d = dsu_pkg::ST_CA_RD;
      end
      dsu_pkg::ST_FB_RD: begin
        cmd_o.par_rd = 1'b1;
        state_d = dsu_pkg::ST_FB_CHK;
      end
      dsu_pkg::ST_FB_CHK: begin
        if (sts_i.par_is_root) begin
          cmd_o.root_we_b = 1'b1;
          cmd_o.cur_sel   = dsu_pkg::CUR_B;
          state_d = dsu_pkg::ST_CB_RD;
        end else begin
          cmd_o.cur_sel = dsu_pkg::CUR_PAR;
          state_d = dsu_pkg::ST_FB_RD;
        end
      end
      dsu_pkg::ST_CB_RD: begin
        if (sts_i.cur_is_rb) begin
          if (sts_i.roots_eq) begin
            cmd_o.res_same = 1'b1;
            state_d = dsu_pkg::ST_DONE;
          end else begin
            cmd_o.sz_rd_a = 1'b1;
            state_d = dsu_pkg::ST_SZ_B;
          end
        end else begin
          cmd_o.par_rd = 1'b1;
          state_d = dsu_pkg::ST_CB_CHK;
        end
      end
      dsu_pkg::ST_CB_CHK: begin
        cmd_o.par_wr     = 1'b1;
        cmd_o.root_sel_b = 1'b1;
        cmd_o.cur_sel    = dsu_pkg::CUR_PAR;
        state_d = dsu_pkg::ST_CB_RD;
      end
      dsu_pkg::ST_SZ_B: begin
        cmd_o.sz_rd_b = 1'b1;
        state_d = dsu_pkg::ST_LINK;
      end
      dsu_pkg::ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d = dsu_pkg::ST_DONE;
      end
      dsu_pkg::ST_DONE: begin
        // hold the result until the output register has room
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = dsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dsu_datapath.sv
// Parent and size memories, walk registers, linking logic and output register.
`timescale 1ns / 1ps

module dsu_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dsu_pkg::NODE_W-1:0] node_a_i,
  input  logic [dsu_pkg::NODE_W-1:0] node_b_i,
  input  dsu_pkg::cmd_t              cmd_i,
  output dsu_pkg::sts_t              sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       merged_o,
  output logic [dsu_pkg::NODE_W-1:0] root_o
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [dsu_pkg::NODE_W:0] LimitL = (dsu_pkg::NODE_W + 1)'(DEPTH);

  logic [dsu_pkg::NODE_W-1:0] par_mem [DEPTH];
  logic [dsu_pkg::SIZE_W-1:0] sz_mem  [DEPTH];

  logic [AW-1:0]              clr_q;
  logic [dsu_pkg::NODE_W-1:0] a_q, b_q, cur_q, cur_d, ra_q, rb_q;
  logic [dsu_pkg::NODE_W-1:0] par_rd_q;
  logic [dsu_pkg::SIZE_W-1:0] sz_rd_q, sa_q;
  logic                       res_merged_q;
  logic [dsu_pkg::NODE_W-1:0] res_root_q;
  logic                       out_valid_q;
  logic                       out_merged_q;
  logic [dsu_pkg::NODE_W-1:0] out_root_q;

  logic                       swap;
  logic [dsu_pkg::NODE_W-1:0] small_root, big_root;
  logic [dsu_pkg::SIZE_W:0]   size_sum;
  logic [dsu_pkg::SIZE_W-1:0] size_sat;

  logic                       par_we;
  logic [AW-1:0]              par_waddr;
  logic [dsu_pkg::NODE_W-1:0] par_wdata;
  logic                       sz_we;
  logic [AW-1:0]              sz_waddr;
  logic [dsu_pkg::SIZE_W-1:0] sz_wdata;
  logic [AW-1:0]              sz_raddr;

  // smaller set goes under the larger; ties put node_a's root under node_b's
  assign swap       = sa_q > sz_rd_q;
  assign small_root = swap ? rb_q : ra_q;
  assign big_root   = swap ? ra_q : rb_q;
  assign size_sum   = {1'b0, sa_q} + {1'b0, sz_rd_q};
  assign size_sat   = size_sum[dsu_pkg::SIZE_W] ? dsu_pkg::SIZE_MAX
                                                : size_sum[dsu_pkg::SIZE_W-1:0];

  always_comb begin
    par_we    = cmd_i.clr_step | cmd_i.par_wr | cmd_i.link;
    par_waddr = small_root[AW-1:0];
    par_wdata = big_root;
    if (cmd_i.clr_step) begin
      par_waddr = clr_q;
      par_wdata = dsu_pkg::NODE_W'(clr_q);
    end else if (cmd_i.par_wr) begin
      par_waddr = cur_q[AW-1:0];
      par_wdata = cmd_i.root_sel_b ? rb_q : ra_q;
    end
    sz_we    = cmd_i.clr_step | cmd_i.link;
    sz_waddr = cmd_i.clr_step ? clr_q : big_root[AW-1:0];
    sz_wdata = cmd_i.clr_step ? dsu_pkg::SIZE_ONE : size_sat;
    sz_raddr = cmd_i.sz_rd_b ? rb_q[AW-1:0] : ra_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (cmd_i.par_rd) begin
      par_rd_q <= par_mem[cur_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sz_we) begin
      sz_mem[sz_waddr] <= sz_wdata;
    end
    if (cmd_i.sz_rd_a || cmd_i.sz_rd_b) begin
      sz_rd_q <= sz_mem[sz_raddr];
    end
  end

  always_comb begin
    case (cmd_i.cur_sel)
      dsu_pkg::CUR_A:   cur_d = a_q;
      dsu_pkg::CUR_B:   cur_d = b_q;
      dsu_pkg::CUR_PAR: cur_d = par_rd_q;
      default:          cur_d = cur_q;
    endcase
    if (cmd_i.load_req) begin
      cur_d = node_a_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.load_req) begin
      a_q <= node_a_i;
      b_q <= node_b_i;
    end
    if (cmd_i.root_we_a) begin
      ra_q <= cur_q;
    end
    if (cmd_i.root_we_b) begin
      rb_q <= cur_q;
    end
    // first size read lands while the second is issued
    if (cmd_i.sz_rd_b) begin
      sa_q <= sz_rd_q;
    end
    if (cmd_i.res_null) begin
      res_merged_q <= 1'b0;
      res_root_q   <= '0;
    end else if (cmd_i.res_same) begin
      res_merged_q <= 1'b0;
      res_root_q   <= ra_q;
    end else if (cmd_i.link) begin
      res_merged_q <= 1'b1;
      res_root_q   <= big_root;
    end
    if (cmd_i.out_load) begin
      out_merged_q <= res_merged_q;
      out_root_q   <= res_root_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last    = (clr_q == AW'(DEPTH - 1));
  assign sts_o.par_is_root = (par_rd_q == cur_q);
  assign sts_o.cur_is_ra   = (cur_q == ra_q);
  assign sts_o.cur_is_rb   = (cur_q == rb_q);
  assign sts_o.roots_eq    = (ra_q == rb_q);
  assign sts_o.req_oob     = ({1'b0, node_a_i} >= LimitL) || ({1'b0, node_b_i} >= LimitL);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign merged_o    = out_merged_q;
  assign root_o      = out_root_q;

endmodule

>>> rtl/disjoint_set_union_engine.sv
// Union-find engine top level: request and result streams around the sequencer and datapath.
// Usage: each request on the slave stream names two nodes; the engine finds both roots,
// repoints every node on the walked paths at its root, and joins the two sets by size
// (smaller under larger, ties put node_a's root under node_b's). One result per request
// leaves on the master stream: merged flag and the surviving root.
// Nodes at or above NODES (when NODES is below 1024) give merged 0, root 0, no change.
// Sequence: after acceptance both roots are found, each parent link followed on a walk
// taking a read, then a compare on the registered data; each node repointed adds a read
// and a write; distinct roots then take the two size reads and the link, equal roots skip
// them. The single read port of the parent memory sets this order.
// Requests: one at a time; the next is accepted the cycle after the result is loaded into
// the output register.
// Reset: a clearing pass over the first min(NODES, 1024) entries writes every parent entry
// with its own index and every size with one; s_axis_tready stays low until it ends.
// Stall: the result sits in an output register, so the next request is accepted while
// it waits; a second result is held inside until the master side takes the first.
`timescale 1ns / 1ps

module disjoint_set_union_engine #(
  parameter int NODES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [dsu_pkg::IN_W-1:0]  s_axis_tdata,  // node_a[9:0], node_b[19:10], zero pad
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [dsu_pkg::OUT_W-1:0] m_axis_tdata   // merged[0], root[10:1], zero pad
);

  localparam int DEPTH = (NODES < dsu_pkg::NODE_CNT) ? NODES : dsu_pkg::NODE_CNT;

  dsu_pkg::cmd_t              cmd;
  dsu_pkg::sts_t              sts;
  logic                       merged;
  logic [dsu_pkg::NODE_W-1:0] root;

  dsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsu_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .node_a_i    (s_axis_tdata[dsu_pkg::NODE_W-1:0]),
    .node_b_i    (s_axis_tdata[2*dsu_pkg::NODE_W-1:dsu_pkg::NODE_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .merged_o    (merged),
    .root_o      (root)
  );

  assign m_axis_tdata = {(dsu_pkg::OUT_W - dsu_pkg::NODE_W - 1)'(0), root, merged};

  // a finished result never overwrites one still waiting on the master side
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending result");

  // linking only happens between two different roots
  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link |-> !sts.roots_eq)
    else $error("link issued with equal roots");

  // memory write sources are exclusive
  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.par_wr, cmd.link}))
    else $error("conflicting parent memory writes");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the union-find engine: request stream in, merge results out.
`timescale 1ns / 1ps

class union_board;
  typedef struct packed {
    bit                      merged;
    bit [dsu_pkg::NODE_W-1:0] root;
  } join_result_t;

  bit [dsu_pkg::NODE_W-1:0] parent   [dsu_pkg::NODE_CNT];
  bit [dsu_pkg::SIZE_W-1:0] set_size [dsu_pkg::NODE_CNT];
  join_result_t             join_results [$];
  int errors;
  int requests;
  int joins;
  int same_set;
  int checked;
  int deepest_walk;

  function new();
    for (int i = 0; i < dsu_pkg::NODE_CNT; i++) begin
      parent[i]   = dsu_pkg::NODE_W'(i);
      set_size[i] = dsu_pkg::SIZE_ONE;
    end
    errors = 0;
    requests = 0;
    joins = 0;
    same_set = 0;
    checked = 0;
    deepest_walk = 0;
  endfunction

  // Walk to the root, then point every node on the path straight at it.
  function bit [dsu_pkg::NODE_W-1:0] find_and_flatten(bit [dsu_pkg::NODE_W-1:0] n);
    bit [dsu_pkg::NODE_W-1:0] r;
    bit [dsu_pkg::NODE_W-1:0] cur;
    bit [dsu_pkg::NODE_W-1:0] nxt;
    int links;
    r = n;
    links = 0;
    while (parent[r] != r) begin
      r = parent[r];
      links++;
    end
    if (links > deepest_walk) deepest_walk = links;
    cur = n;
    while (cur != r) begin
      nxt = parent[cur];
      parent[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  function void note_request(bit [dsu_pkg::NODE_W-1:0] a, bit [dsu_pkg::NODE_W-1:0] b);
    bit [dsu_pkg::NODE_W-1:0] ra;
    bit [dsu_pkg::NODE_W-1:0] rb;
    bit [dsu_pkg::NODE_W-1:0] t;
    bit [dsu_pkg::SIZE_W:0]   sum;
    join_result_t res;
    requests++;
    ra = find_and_flatten(a);
    rb = find_and_flatten(b);
    if (ra == rb) begin
      res.merged = 1'b0;
      res.root   = ra;
      same_set++;
    end else begin
      // smaller set goes under the larger one; on a tie node_a's root goes under
      if (set_size[ra] > set_size[rb]) begin
        t  = ra;
        ra = rb;
        rb = t;
      end
      parent[ra] = rb;
      sum = {1'b0, set_size[rb]} + {1'b0, set_size[ra]};
      set_size[rb] = sum[dsu_pkg::SIZE_W] ? dsu_pkg::SIZE_MAX : sum[dsu_pkg::SIZE_W-1:0];
      res.merged = 1'b1;
      res.root   = rb;
      joins++;
    end
    join_results.insert(join_results.size(), res);
  endfunction

  function void check_result(bit merged, bit [dsu_pkg::NODE_W-1:0] root);
    join_result_t want;
    checked++;
    if (join_results.size() == 0) begin
      $display("%0t: result with nothing pending: merged %0d root %0d", $time, merged, root);
      errors++;
      return;
    end
    want = join_results[0];
    join_results.delete(0);
    if (merged != want.merged) begin
      $display("%0t: merged mismatch: expected %0d, actual %0d", $time, want.merged, merged);
      errors++;
    end
    if (root != want.root) begin
      $display("%0t: root mismatch: expected %0d, actual %0d", $time, want.root, root);
      errors++;
    end
  endfunction

  function int outstanding();
    return join_results.size();
  endfunction
endclass

module tb_top;

  localparam int STUCK_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 600;
  localparam int DIR_N        = 20;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [dsu_pkg::IN_W-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [dsu_pkg::OUT_W-1:0] m_axis_tdata;

  // edge cases: same node twice, extremes, ties, larger first node, a depth-3 tree
  logic [dsu_pkg::NODE_W-1:0] dir_a [DIR_N] = '{0, 1023, 0, 0, 1023, 1, 1, 4, 2, 32,
                                                34, 36, 38, 32, 36, 32, 32, 33, 682, 512};
  logic [dsu_pkg::NODE_W-1:0] dir_b [DIR_N] = '{0, 1023, 1023, 1023, 0, 2, 3, 1, 2, 33,
                                                35, 37, 39, 34, 38, 36, 1, 1023, 341, 511};

  union_board board;
  bit         burst_mode;

  always #5 clk_i = ~clk_i;

  disjoint_set_union_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(logic [dsu_pkg::NODE_W-1:0] a, logic [dsu_pkg::NODE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(dsu_pkg::IN_W - 2 * dsu_pkg::NODE_W){1'b0}}, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(a, b);
  endtask

  initial begin : request_source
    logic [dsu_pkg::NODE_W-1:0] a;
    logic [dsu_pkg::NODE_W-1:0] b;
    int base;
    int span;
    int r;
    board = new();
    burst_mode = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) send_request(dir_a[i], dir_b[i]);

    base = 0;
    span = 16;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // move the working window now and then so separate clusters grow and later join
      if (i % 40 == 0) begin
        base = $urandom_range(0, dsu_pkg::NODE_CNT - 1);
        case ($urandom_range(0, 3))
          0: span = 4;
          1: span = 16;
          2: span = 64;
          default: span = 256;
        endcase
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      a = dsu_pkg::NODE_W'(base + $urandom_range(0, span - 1));
      b = dsu_pkg::NODE_W'(base + $urandom_range(0, span - 1));
      if (r < 5) begin
        b = a;
      end else if (r >= 80) begin
        a = dsu_pkg::NODE_W'($urandom_range(0, dsu_pkg::NODE_CNT - 1));
        b = dsu_pkg::NODE_W'($urandom_range(0, dsu_pkg::NODE_CNT - 1));
      end
      send_request(a, b);
    end
    s_axis_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("tb_top: %0d requests, %0d joins, %0d already in one set", board.requests,
             board.joins, board.same_set);
    $display("tb_top: longest parent walk %0d links, %0d results checked",
             board.deepest_walk, board.checked);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int  stall_left;
    int  r;
    bit  quiet;
    bit  held;
    stall_left = 0;
    quiet = 1'b0;
    held  = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata[0], m_axis_tdata[dsu_pkg::NODE_W:1]);
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      // one long hold-off mid-run so the engine backs up and stalls its input
      if (!held && board.checked >= 150) begin
        held = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
